>>> hdl/pmc_pkg.sv
// Shared types and constants of the maze carver.
// Used by the top level, its checkers and the testbench; no dependencies.
package pmc_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int LW         = $clog2(CELLS);

  // Opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;  // unused code: no state change

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SPARE_2     = 2'd2;  // no register behind it
  localparam logic [1:0] REG_SPARE_3     = 2'd3;  // no register behind it

  localparam logic [6:0] RESET_WIDTH  = 7'd32;
  localparam logic [6:0] RESET_HEIGHT = 7'd16;

  // Neighbour offsets, two cells away
  localparam logic signed [8:0] NBR_DX [4] = '{9'sd2, -9'sd2, 9'sd0, 9'sd0};
  localparam logic signed [8:0] NBR_DY [4] = '{9'sd0, 9'sd0, 9'sd2, -9'sd2};

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  pos_x;
    logic [5:0]  pos_y;
    logic [15:0] random_pick;
  } in_item_t;

  typedef struct packed {
    logic        done_res;
    logic        carved;
    logic [5:0]  new_cell_x;
    logic [5:0]  new_cell_y;
    logic [5:0]  wall_x;
    logic [5:0]  wall_y;
    logic        cell_is_path;
    logic [12:0] frontier_count;
  } out_item_t;

  // One grid row: frontier marks above path bits
  typedef struct packed {
    logic [MAX_WIDTH-1:0] mark;
    logic [MAX_WIDTH-1:0] path;
  } row_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ_RD,
    S_READ_CAP,
    S_MUL,
    S_LRD_K,
    S_LRD_L,
    S_LWR,
    S_UNMARK_RD,
    S_UNMARK_WR,
    S_C1_RD,
    S_C2_RD,
    S_C2_CAP,
    S_CW_WR,
    S_CN_RD,
    S_CN_WR,
    S_PN_RD,
    S_PW_RD,
    S_PW_WR,
    S_OUT
  } state_t;

endpackage

>>> hdl/prim_maze_carver.sv
// Top level of the randomised Prim maze carver.
// Depends on pmc_pkg and pmc_ram.
//
// Throughput: one transaction at a time; the next start is taken the cycle after the strobe.
// Every grid update is a read, a capture and a write-back of the row memory in turn.
// Reset is synchronous; the grid needs no clearing pass because a valid bit per
// row, cleared on reset and on start, makes an unwritten row read as zero. The
// result receiver cannot stall the block.
module prim_maze_carver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pmc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output pmc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  // Odd cell strictly inside the border of a w x h grid
  function automatic logic odd_cell(input logic signed [8:0] x, input logic signed [8:0] y,
                                    input logic [6:0] w, input logic [6:0] h);
    logic signed [8:0] ws;
    logic signed [8:0] hs;
    ws = $signed({2'b00, w});
    hs = $signed({2'b00, h});
    return (x >= 9'sd1) && (x + 9'sd1 < ws) && (y >= 9'sd1) && (y + 9'sd1 < hs)
           && x[0] && y[0];
  endfunction

  pmc_pkg::state_t   state_r, state_nxt;
  pmc_pkg::in_item_t cmd_r, cmd_nxt;
  logic [6:0]        gw_r, gh_r;
  logic [12:0]       size_r, size_nxt;
  logic              done_r, done_nxt;
  logic [pmc_pkg::MAX_HEIGHT-1:0] rowv_r, rowv_nxt;
  logic              gvq_r;
  logic [11:0]       k_r, k_nxt;
  logic [5:0]        wall_x_r, wall_x_nxt, wall_y_r, wall_y_nxt;
  logic [5:0]        cell_x_r, cell_x_nxt, cell_y_r, cell_y_nxt;
  logic              v1_r, v1_nxt, np_r, np_nxt;
  logic [1:0]        nbr_r, nbr_nxt;
  logic              carved_r, carved_nxt, took_r, took_nxt, rd_r, rd_nxt;

  // Row memory ports
  logic                     g_re, g_we;
  logic [pmc_pkg::YW-1:0]   g_raddr, g_waddr;
  pmc_pkg::row_t            g_wdata, g_q, row_rd;

  // Frontier list memory ports
  logic                     f_re, f_we;
  logic [pmc_pkg::LW-1:0]   f_raddr, f_waddr;
  logic [11:0]              f_wdata, f_q;

  pmc_ram #(.WIDTH($bits(pmc_pkg::row_t)), .DEPTH(pmc_pkg::MAX_HEIGHT)) u_rows (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(g_re), .raddr(g_raddr), .rdata(g_q)
  );

  pmc_ram #(.WIDTH(12), .DEPTH(pmc_pkg::CELLS)) u_frontier (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_q)
  );

  // A row never written since the last start reads as all zero
  assign row_rd = gvq_r ? g_q : '0;

  // Clamp the configured sizes to the store dimensions
  logic [6:0] wc, hc;
  assign wc = (gw_r > 7'(pmc_pkg::MAX_WIDTH))  ? 7'(pmc_pkg::MAX_WIDTH)  : gw_r;
  assign hc = (gh_r > 7'(pmc_pkg::MAX_HEIGHT)) ? 7'(pmc_pkg::MAX_HEIGHT) : gh_r;

  // Frontier pick index: (random * count) >> 16, always below the count
  logic [28:0] prod;
  assign prod = {13'd0, cmd_r.random_pick} * {16'd0, size_r};

  // The two cells either side of the taken wall
  logic              horiz, vert, cells_ok;
  logic signed [8:0] c1x, c1y, c2x, c2y, wxs, wys;
  assign wxs   = $signed({3'b000, wall_x_r});
  assign wys   = $signed({3'b000, wall_y_r});
  assign horiz = !wall_x_r[0] && wall_y_r[0];
  assign vert  = wall_x_r[0] && !wall_y_r[0];
  assign c1x   = horiz ? wxs - 9'sd1 : wxs;
  assign c2x   = horiz ? wxs + 9'sd1 : wxs;
  assign c1y   = vert ? wys - 9'sd1 : wys;
  assign c2y   = vert ? wys + 9'sd1 : wys;
  assign cells_ok = (horiz || vert) && odd_cell(c1x, c1y, wc, hc) && odd_cell(c2x, c2y, wc, hc);

  // Neighbour under test while pushing walls, and the wall towards it
  logic signed [8:0] pnx, pny, pwx, pwy;
  assign pnx = $signed({3'b000, cell_x_r}) + pmc_pkg::NBR_DX[nbr_r];
  assign pny = $signed({3'b000, cell_y_r}) + pmc_pkg::NBR_DY[nbr_r];
  assign pwx = $signed({3'b000, cell_x_r}) + (pmc_pkg::NBR_DX[nbr_r] >>> 1);
  assign pwy = $signed({3'b000, cell_y_r}) + (pmc_pkg::NBR_DY[nbr_r] >>> 1);

  logic start_ok;
  assign start_ok = (wc >= 7'd3) && (hc >= 7'd3)
                    && odd_cell($signed({3'b000, in_data.pos_x}),
                                $signed({3'b000, in_data.pos_y}), wc, hc);

  logic v2;
  assign v2 = row_rd.path[c2x[5:0]];

  // Sequencer: reads and writes to the row memory never share a cycle, so a
  // read always sees the write-back issued before it (interlock by ordering).
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    size_nxt   = size_r;
    done_nxt   = done_r;
    rowv_nxt   = rowv_r;
    k_nxt      = k_r;
    wall_x_nxt = wall_x_r;
    wall_y_nxt = wall_y_r;
    cell_x_nxt = cell_x_r;
    cell_y_nxt = cell_y_r;
    v1_nxt     = v1_r;
    np_nxt     = np_r;
    nbr_nxt    = nbr_r;
    carved_nxt = carved_r;
    took_nxt   = took_r;
    rd_nxt     = rd_r;
    g_re       = 1'b0;
    g_we       = 1'b0;
    g_raddr    = '0;
    g_waddr    = '0;
    g_wdata    = row_rd;
    f_re       = 1'b0;
    f_we       = 1'b0;
    f_raddr    = '0;
    f_waddr    = '0;
    f_wdata    = f_q;

    unique case (state_r)
      pmc_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_data;
          carved_nxt = 1'b0;
          took_nxt   = 1'b0;
          rd_nxt     = 1'b0;
          case (in_data.opcode)
            pmc_pkg::OP_START: begin
              rowv_nxt = '0;
              size_nxt = '0;
              if (start_ok) begin
                done_nxt   = 1'b0;
                cell_x_nxt = in_data.pos_x;
                cell_y_nxt = in_data.pos_y;
                state_nxt  = pmc_pkg::S_CN_RD;
              end else begin
                done_nxt  = 1'b1;
                state_nxt = pmc_pkg::S_OUT;
              end
            end
            pmc_pkg::OP_STEP: begin
              if (size_r == '0) begin
                done_nxt  = 1'b1;
                state_nxt = pmc_pkg::S_OUT;
              end else begin
                state_nxt = pmc_pkg::S_MUL;
              end
            end
            pmc_pkg::OP_READ: begin
              if ({1'b0, in_data.pos_x} < wc && {1'b0, in_data.pos_y} < hc) begin
                state_nxt = pmc_pkg::S_READ_RD;
              end else begin
                state_nxt = pmc_pkg::S_OUT;
              end
            end
            default: state_nxt = pmc_pkg::S_OUT;
          endcase
        end
      end
      pmc_pkg::S_READ_RD: begin
        g_re      = 1'b1;
        g_raddr   = cmd_r.pos_y;
        state_nxt = pmc_pkg::S_READ_CAP;
      end
      pmc_pkg::S_READ_CAP: begin
        rd_nxt    = row_rd.path[cmd_r.pos_x];
        state_nxt = pmc_pkg::S_OUT;
      end
      pmc_pkg::S_MUL: begin
        k_nxt     = prod[27:16];
        state_nxt = pmc_pkg::S_LRD_K;
      end
      pmc_pkg::S_LRD_K: begin
        f_re      = 1'b1;
        f_raddr   = k_r;
        state_nxt = pmc_pkg::S_LRD_L;
      end
      pmc_pkg::S_LRD_L: begin
        wall_x_nxt = f_q[5:0];
        wall_y_nxt = f_q[11:6];
        took_nxt   = 1'b1;
        f_re       = 1'b1;
        f_raddr    = 12'(size_r - 13'd1);
        state_nxt  = pmc_pkg::S_LWR;
      end
      pmc_pkg::S_LWR: begin
        // Move the last entry into the hole
        f_we      = 1'b1;
        f_waddr   = k_r;
        f_wdata   = f_q;
        size_nxt  = size_r - 13'd1;
        state_nxt = pmc_pkg::S_UNMARK_RD;
      end
      pmc_pkg::S_UNMARK_RD: begin
        g_re      = 1'b1;
        g_raddr   = wall_y_r;
        state_nxt = pmc_pkg::S_UNMARK_WR;
      end
      pmc_pkg::S_UNMARK_WR: begin
        g_we      = 1'b1;
        g_waddr   = wall_y_r;
        g_wdata.mark[wall_x_r] = 1'b0;
        rowv_nxt[wall_y_r] = 1'b1;
        state_nxt = cells_ok ? pmc_pkg::S_C1_RD : pmc_pkg::S_OUT;
      end
      pmc_pkg::S_C1_RD: begin
        g_re      = 1'b1;
        g_raddr   = c1y[5:0];
        state_nxt = pmc_pkg::S_C2_RD;
      end
      pmc_pkg::S_C2_RD: begin
        v1_nxt    = row_rd.path[c1x[5:0]];
        g_re      = 1'b1;
        g_raddr   = c2y[5:0];
        state_nxt = pmc_pkg::S_C2_CAP;
      end
      pmc_pkg::S_C2_CAP: begin
        if (v1_r != v2) begin
          carved_nxt = 1'b1;
          cell_x_nxt = v1_r ? c2x[5:0] : c1x[5:0];
          cell_y_nxt = v1_r ? c2y[5:0] : c1y[5:0];
          g_re       = 1'b1;
          g_raddr    = wall_y_r;
          state_nxt  = pmc_pkg::S_CW_WR;
        end else begin
          state_nxt  = pmc_pkg::S_OUT;
        end
      end
      pmc_pkg::S_CW_WR: begin
        g_we      = 1'b1;
        g_waddr   = wall_y_r;
        g_wdata.path[wall_x_r] = 1'b1;
        rowv_nxt[wall_y_r] = 1'b1;
        state_nxt = pmc_pkg::S_CN_RD;
      end
      pmc_pkg::S_CN_RD: begin
        g_re      = 1'b1;
        g_raddr   = cell_y_r;
        state_nxt = pmc_pkg::S_CN_WR;
      end
      pmc_pkg::S_CN_WR: begin
        g_we      = 1'b1;
        g_waddr   = cell_y_r;
        g_wdata.path[cell_x_r] = 1'b1;
        rowv_nxt[cell_y_r] = 1'b1;
        nbr_nxt   = '0;
        state_nxt = pmc_pkg::S_PN_RD;
      end
      pmc_pkg::S_PN_RD: begin
        if (odd_cell(pnx, pny, wc, hc)) begin
          g_re      = 1'b1;
          g_raddr   = pny[5:0];
          state_nxt = pmc_pkg::S_PW_RD;
        end else if (nbr_r == 2'd3) begin
          state_nxt = pmc_pkg::S_OUT;
        end else begin
          nbr_nxt   = nbr_r + 2'd1;
        end
      end
      pmc_pkg::S_PW_RD: begin
        np_nxt    = row_rd.path[pnx[5:0]];
        g_re      = 1'b1;
        g_raddr   = pwy[5:0];
        state_nxt = pmc_pkg::S_PW_WR;
      end
      pmc_pkg::S_PW_WR: begin
        if (!np_r && !row_rd.mark[pwx[5:0]] && size_r < 13'(pmc_pkg::CELLS)) begin
          g_we      = 1'b1;
          g_waddr   = pwy[5:0];
          g_wdata.mark[pwx[5:0]] = 1'b1;
          rowv_nxt[pwy[5:0]] = 1'b1;
          f_we      = 1'b1;
          f_waddr   = size_r[11:0];
          f_wdata   = {pwy[5:0], pwx[5:0]};
          size_nxt  = size_r + 13'd1;
        end
        if (nbr_r == 2'd3) begin
          state_nxt = pmc_pkg::S_OUT;
        end else begin
          nbr_nxt   = nbr_r + 2'd1;
          state_nxt = pmc_pkg::S_PN_RD;
        end
      end
      pmc_pkg::S_OUT: state_nxt = pmc_pkg::S_IDLE;
      default: state_nxt = pmc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmc_pkg::S_IDLE;
      size_r  <= '0;
      done_r  <= 1'b1;
      rowv_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      done_r  <= done_nxt;
      rowv_r  <= rowv_nxt;
    end
  end

  // Configuration writes; always accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= pmc_pkg::RESET_WIDTH;
      gh_r <= pmc_pkg::RESET_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmc_pkg::REG_GRID_WIDTH:  gw_r <= cfg_data;
        pmc_pkg::REG_GRID_HEIGHT: gh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers: hold without reset
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    k_r      <= k_nxt;
    wall_x_r <= wall_x_nxt;
    wall_y_r <= wall_y_nxt;
    cell_x_r <= cell_x_nxt;
    cell_y_r <= cell_y_nxt;
    v1_r     <= v1_nxt;
    np_r     <= np_nxt;
    nbr_r    <= nbr_nxt;
    carved_r <= carved_nxt;
    took_r   <= took_nxt;
    rd_r     <= rd_nxt;
    if (g_re) begin
      gvq_r <= rowv_r[g_raddr];
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != pmc_pkg::S_IDLE);
  assign out_valid = (state_r == pmc_pkg::S_OUT);

  always_comb begin
    out_data.done_res       = done_r;
    out_data.carved         = carved_r;
    out_data.new_cell_x     = carved_r ? cell_x_r : 6'd0;
    out_data.new_cell_y     = carved_r ? cell_y_r : 6'd0;
    out_data.wall_x         = took_r ? wall_x_r : 6'd0;
    out_data.wall_y         = took_r ? wall_y_r : 6'd0;
    out_data.cell_is_path   = rd_r;
    out_data.frontier_count = size_r;
  end

endmodule

>>> hdl/pmc_ram.sv
// Generic single-clock RAM: one write and one read port, registered read data.
// Used by the maze carver for grid rows and the frontier list; no dependencies.
module pmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/pmc_checker.sv
// Port-level checks for the maze carver, attached by bind.
// Depends on pmc_pkg and the prim_maze_carver top level.
module pmc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input pmc_pkg::out_item_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without a transaction in flight");

  a_carve_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.carved |-> out_data.new_cell_x[0] && out_data.new_cell_y[0])
    else $error("carved cell not on odd coordinates");

  a_carve_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.carved |-> !out_data.done_res)
    else $error("carve reported on a finished maze");

endmodule

bind prim_maze_carver pmc_checker u_pmc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

>>> tb/sv/maze_checker.sv
`timescale 1ns / 1ps
// Checker for the maze carver: watches the command, result and register channels.
// Holds its own copy of the grid and frontier; depends on pmc_pkg only.
module maze_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  pmc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  pmc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output int                 err_count,
  output int                 pending
);

  localparam int STEP_DX [4] = '{2, -2, 0, 0};
  localparam int STEP_DY [4] = '{0, 0, 2, -2};

  bit        path_bit [pmc_pkg::CELLS];
  bit        mark_bit [pmc_pkg::CELLS];
  logic [5:0] wall_list_x [pmc_pkg::CELLS];
  logic [5:0] wall_list_y [pmc_pkg::CELLS];
  int        wall_total;
  bit        maze_over;
  logic [6:0] width_reg;
  logic [6:0] height_reg;
  pmc_pkg::out_item_t result_q [$];

  function automatic int eff_w();
    return (width_reg > pmc_pkg::MAX_WIDTH) ? pmc_pkg::MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int eff_h();
    return (height_reg > pmc_pkg::MAX_HEIGHT) ? pmc_pkg::MAX_HEIGHT : int'(height_reg);
  endfunction

  function automatic bit is_room(int x, int y, int w, int h);
    return x > 0 && x < w - 1 && y > 0 && y < h - 1 && x[0] && y[0];
  endfunction

  function automatic void add_walls(int cx, int cy);
    int nx, ny, wx, wy, wi;
    for (int i = 0; i < 4; i++) begin
      nx = cx + STEP_DX[i];
      ny = cy + STEP_DY[i];
      wx = cx + STEP_DX[i] / 2;
      wy = cy + STEP_DY[i] / 2;
      if (!is_room(nx, ny, eff_w(), eff_h())) continue;
      if (path_bit[ny * pmc_pkg::MAX_WIDTH + nx]) continue;
      wi = wy * pmc_pkg::MAX_WIDTH + wx;
      if (!mark_bit[wi] && wall_total < pmc_pkg::CELLS) begin
        mark_bit[wi] = 1'b1;
        wall_list_x[wall_total] = wx[5:0];
        wall_list_y[wall_total] = wy[5:0];
        wall_total++;
      end
    end
  endfunction

  // Work out the result of one command and advance the model state
  function automatic pmc_pkg::out_item_t carve_outcome(pmc_pkg::in_item_t it);
    pmc_pkg::out_item_t r;
    int w, h, px, py, k, wx, wy, c1x, c1y, c2x, c2y, nx, ny;
    bit ok, v1, v2;
    r = '0;
    w = eff_w();
    h = eff_h();
    px = it.pos_x;
    py = it.pos_y;
    if (it.opcode == pmc_pkg::OP_START) begin
      for (int i = 0; i < pmc_pkg::CELLS; i++) begin
        path_bit[i] = 1'b0;
        mark_bit[i] = 1'b0;
      end
      wall_total = 0;
      maze_over = 1'b0;
      if (w < 3 || h < 3 || !is_room(px, py, w, h)) begin
        maze_over = 1'b1;
      end else begin
        path_bit[py * pmc_pkg::MAX_WIDTH + px] = 1'b1;
        add_walls(px, py);
      end
    end else if (it.opcode == pmc_pkg::OP_STEP) begin
      if (wall_total == 0) begin
        maze_over = 1'b1;
      end else begin
        k = int'((longint'(it.random_pick) * wall_total) >> 16);
        wx = wall_list_x[k];
        wy = wall_list_y[k];
        wall_total--;
        wall_list_x[k] = wall_list_x[wall_total];
        wall_list_y[k] = wall_list_y[wall_total];
        mark_bit[wy * pmc_pkg::MAX_WIDTH + wx] = 1'b0;
        r.wall_x = wx[5:0];
        r.wall_y = wy[5:0];
        ok = 1'b1;
        c1x = 0; c1y = 0; c2x = 0; c2y = 0;
        if (!wx[0] && wy[0]) begin
          c1x = wx - 1; c1y = wy; c2x = wx + 1; c2y = wy;
        end else if (wx[0] && !wy[0]) begin
          c1x = wx; c1y = wy - 1; c2x = wx; c2y = wy + 1;
        end else begin
          ok = 1'b0;
        end
        if (ok && is_room(c1x, c1y, w, h) && is_room(c2x, c2y, w, h)) begin
          v1 = path_bit[c1y * pmc_pkg::MAX_WIDTH + c1x];
          v2 = path_bit[c2y * pmc_pkg::MAX_WIDTH + c2x];
          if (v1 != v2) begin
            nx = v1 ? c2x : c1x;
            ny = v1 ? c2y : c1y;
            path_bit[wy * pmc_pkg::MAX_WIDTH + wx] = 1'b1;
            path_bit[ny * pmc_pkg::MAX_WIDTH + nx] = 1'b1;
            add_walls(nx, ny);
            r.carved = 1'b1;
            r.new_cell_x = nx[5:0];
            r.new_cell_y = ny[5:0];
          end
        end
      end
    end else if (it.opcode == pmc_pkg::OP_READ) begin
      if (px < w && py < h) r.cell_is_path = path_bit[py * pmc_pkg::MAX_WIDTH + px];
    end
    r.done_res = maze_over;
    r.frontier_count = wall_total[12:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %0t: %s got %0d want %0d", $realtime, field, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    pmc_pkg::out_item_t want;
    if (!rst_n) begin
      width_reg  <= pmc_pkg::RESET_WIDTH;
      height_reg <= pmc_pkg::RESET_HEIGHT;
      err_count  = 0;
      wall_total = 0;
      maze_over  = 1'b1;
      for (int i = 0; i < pmc_pkg::CELLS; i++) begin
        path_bit[i] = 1'b0;
        mark_bit[i] = 1'b0;
      end
      result_q.delete();
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("mismatch %0t: result with nothing outstanding", $realtime);
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (out_data.done_res != want.done_res)
            report_mismatch("done_res", out_data.done_res, want.done_res);
          if (out_data.carved != want.carved)
            report_mismatch("carved", out_data.carved, want.carved);
          if (out_data.new_cell_x != want.new_cell_x)
            report_mismatch("new_cell_x", out_data.new_cell_x, want.new_cell_x);
          if (out_data.new_cell_y != want.new_cell_y)
            report_mismatch("new_cell_y", out_data.new_cell_y, want.new_cell_y);
          if (out_data.wall_x != want.wall_x)
            report_mismatch("wall_x", out_data.wall_x, want.wall_x);
          if (out_data.wall_y != want.wall_y)
            report_mismatch("wall_y", out_data.wall_y, want.wall_y);
          if (out_data.cell_is_path != want.cell_is_path)
            report_mismatch("cell_is_path", out_data.cell_is_path, want.cell_is_path);
          if (out_data.frontier_count != want.frontier_count)
            report_mismatch("frontier_count", out_data.frontier_count,
                            want.frontier_count);
        end
      end
      if (start && !busy) result_q.push_back(carve_outcome(in_data));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pmc_pkg::REG_GRID_WIDTH) width_reg <= cfg_data;
        else if (cfg_index == pmc_pkg::REG_GRID_HEIGHT) height_reg <= cfg_data;
      end
    end
    pending <= result_q.size();
  end
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the maze carver testbench: clock, reset, command and register stimulus, verdict.
// Depends on pmc_pkg, prim_maze_carver and maze_checker.
module testbench;

  localparam int ITEM_GOAL  = 1650;
  localparam int IDLE_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  pmc_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  pmc_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  int        err_count;
  int        pending;

  int        items_sent = 0;
  int        burst_left = 5;
  int        idle_cycles = 0;
  int        cur_w = 32;
  int        cur_h = 16;

  always #5 clk = ~clk;

  prim_maze_carver dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  maze_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending)
  );

  // Watchdog: any transaction on any channel resets the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Issue one command; hold start across a burst, drop it for a random gap at the end
  task automatic issue(input logic [1:0] op, input int x, input int y, input int pick);
    pmc_pkg::in_item_t it;
    it.opcode      = op;
    it.pos_x       = x[5:0];
    it.pos_y       = y[5:0];
    it.random_pick = pick[15:0];
    start   <= 1'b1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Drop start and wait for every outstanding result
  task automatic drain();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only ever made with the block idle
  task automatic write_reg(input logic [1:0] idx, input int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[6:0];
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == pmc_pkg::REG_GRID_WIDTH) cur_w = value & 127;
    if (idx == pmc_pkg::REG_GRID_HEIGHT) cur_h = value & 127;
  endtask

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(3, 13);
    if (roll < 80) return $urandom_range(0, 2);
    if (roll < 90) return $urandom_range(64, 127);
    return $urandom_range(14, 63);
  endfunction

  // Random odd cell strictly inside the current grid; any position if the grid is under 3
  function automatic int odd_pos(int size);
    int s;
    s = (size > pmc_pkg::MAX_WIDTH) ? pmc_pkg::MAX_WIDTH : size;
    if (s < 3) return $urandom_range(0, 63);
    return 1 + 2 * $urandom_range(0, (s - 1) / 2 - 1);
  endfunction

  task automatic random_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 78) issue(pmc_pkg::OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 65535));
    else if (roll < 96) issue(pmc_pkg::OP_READ, $urandom_range(0, 63),
                              $urandom_range(0, 63), $urandom_range(0, 65535));
    else if (roll < 98) issue(pmc_pkg::OP_NOP, $urandom_range(0, 63),
                              $urandom_range(0, 63), $urandom_range(0, 65535));
    else issue(pmc_pkg::OP_START, $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 65535));
  endtask

  initial begin
    int steps;
    int we;
    int he;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, empty frontier, unused opcode, bad starts
    issue(pmc_pkg::OP_READ, 0, 0, 0);
    issue(pmc_pkg::OP_STEP, 0, 0, 16'hFFFF);
    issue(pmc_pkg::OP_NOP, 63, 63, 16'hFFFF);
    issue(pmc_pkg::OP_START, 2, 2, 0);
    issue(pmc_pkg::OP_START, 63, 63, 0);
    issue(pmc_pkg::OP_START, 31, 15, 0);
    issue(pmc_pkg::OP_START, 1, 1, 0);
    issue(pmc_pkg::OP_STEP, 0, 0, 0);
    issue(pmc_pkg::OP_STEP, 0, 0, 16'hFFFF);
    issue(pmc_pkg::OP_READ, 1, 1, 0);
    write_reg(pmc_pkg::REG_GRID_WIDTH, 0);
    write_reg(pmc_pkg::REG_GRID_HEIGHT, 0);
    issue(pmc_pkg::OP_START, 1, 1, 0);
    write_reg(pmc_pkg::REG_GRID_WIDTH, 3);
    write_reg(pmc_pkg::REG_GRID_HEIGHT, 3);
    issue(pmc_pkg::OP_START, 1, 1, 0);
    issue(pmc_pkg::OP_STEP, 0, 0, 0);
    write_reg(pmc_pkg::REG_GRID_WIDTH, 127);
    write_reg(pmc_pkg::REG_GRID_HEIGHT, 127);
    write_reg(pmc_pkg::REG_SPARE_2, 5);
    write_reg(pmc_pkg::REG_SPARE_3, 5);
    issue(pmc_pkg::OP_START, 61, 61, 0);
    issue(pmc_pkg::OP_STEP, 0, 0, 16'hFFFF);
    issue(pmc_pkg::OP_STEP, 0, 0, 0);
    issue(pmc_pkg::OP_READ, 63, 63, 0);
    issue(pmc_pkg::OP_READ, 61, 61, 0);
    // Shrink the grid under a live maze: reads outside it return wall
    write_reg(pmc_pkg::REG_GRID_WIDTH, 5);
    issue(pmc_pkg::OP_READ, 61, 61, 0);
    issue(pmc_pkg::OP_STEP, 0, 0, 16'h8000);

    // Random phases: configure, start, then mostly steps
    while (items_sent < ITEM_GOAL) begin
      write_reg(pmc_pkg::REG_GRID_WIDTH, pick_size());
      write_reg(pmc_pkg::REG_GRID_HEIGHT, pick_size());
      we = (cur_w > pmc_pkg::MAX_WIDTH) ? pmc_pkg::MAX_WIDTH : cur_w;
      he = (cur_h > pmc_pkg::MAX_HEIGHT) ? pmc_pkg::MAX_HEIGHT : cur_h;
      if ($urandom_range(0, 99) < 88) issue(pmc_pkg::OP_START, odd_pos(cur_w),
                                            odd_pos(cur_h), $urandom_range(0, 65535));
      else issue(pmc_pkg::OP_START, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 65535));
      steps = (we * he) / 2 + 4;
      if (steps > 200) steps = 200;
      for (int i = 0; i < steps; i++) begin
        random_command();
        // Now and then change one of the sizes under a half-grown maze
        if (i == steps / 2 && $urandom_range(0, 9) == 0) begin
          write_reg(2'($urandom_range(0, 1)), pick_size());
        end
        // Hold off until every result is back, once in a while
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
